[design/assert_macros.svh]
// Assertion macros shared by the radial profile interpolator RTL.
// Define NO_ASSERTIONS to compile the checks away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

[design/rpi_pkg.sv]
// Package for the radial profile interpolator: constants, codes and types.
// Used by every module of the block; depends on nothing.
`default_nettype none
package rpi_pkg;
  localparam int TableDepthDef = 1024;
  localparam int ValueWidthDef = 32;
  localparam int RadW = 32;
  localparam int QW = 32;
  localparam int WgtW = 16;

  localparam logic [1:0] ModeAppend = 2'd0;
  localparam logic [1:0] ModeQuery = 2'd1;
  localparam logic [1:0] ModeClear = 2'd2;

  localparam logic [1:0] CfgDensity = 2'd0;
  localparam logic [1:0] CfgTemperature = 2'd1;
  localparam logic [1:0] CfgFraction = 2'd2;

  // Result of one item, handed from the engine to the output stage.
  typedef struct packed {
    logic status;
    logic [QW-1:0] velocity;
    logic [QW-1:0] fraction;
    logic [QW-1:0] temperature;
    logic [QW-1:0] density;
  } result_t;
endpackage
`default_nettype wire

[design/rpi_div.sv]
// Restoring divider for the Q0.16 weight: (off << 16) / span, one bit per cycle.
// Depends on rpi_pkg.
`default_nettype none
`include "assert_macros.svh"
module rpi_div (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  input  wire logic [rpi_pkg::RadW-1:0] off,
  input  wire logic [rpi_pkg::RadW-1:0] span,
  output logic                       done,
  output logic [rpi_pkg::WgtW-1:0]   wgt
);
  import rpi_pkg::*;
  // off <= span, so the quotient fits in 17 bits; 17 steps.
  localparam int Steps = WgtW + 1;
  logic [RadW:0] rem_r, rem_nxt;
  logic [WgtW:0] quo_r, quo_nxt;
  logic [RadW-1:0] span_r;
  logic [4:0] cnt_r, cnt_nxt;
  logic busy_r, busy_nxt;
  logic [RadW+1:0] trial;

  always_comb begin
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    trial = {rem_r, 1'b0} - {2'b00, span_r};
    if (start) begin
      rem_nxt = {1'b0, off};
      quo_nxt = '0;
      cnt_nxt = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // First step takes off itself; later steps shift in zeros.
      if (cnt_r == 5'd0) begin
        trial = {1'b0, rem_r} - {2'b00, span_r};
        if (!trial[RadW+1]) begin
          rem_nxt = trial[RadW:0];
          quo_nxt = {quo_r[WgtW-1:0], 1'b1};
        end else begin
          quo_nxt = {quo_r[WgtW-1:0], 1'b0};
        end
      end else if (!trial[RadW+1]) begin
        rem_nxt = trial[RadW:0];
        quo_nxt = {quo_r[WgtW-1:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[RadW-1:0], 1'b0};
        quo_nxt = {quo_r[WgtW-1:0], 1'b0};
      end
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == 5'(Steps - 1)) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    if (start) span_r <= span;
  end

  assign done = busy_r && (cnt_r == 5'(Steps - 1)) && !start;
  // Saturate a full-span quotient of 65536.
  assign wgt = quo_nxt[WgtW] ? {WgtW{1'b1}} : quo_nxt[WgtW-1:0];

  `ASSERT_NEXT(a_div_busy, clk, rst_n, start, busy_r)
  `ASSERT_IMPL(a_div_cnt, clk, rst_n, busy_r, cnt_r < 5'(Steps))
  `ASSERT_NEXT(a_div_idle, clk, rst_n, done, !busy_r)
endmodule
`default_nettype wire

[design/rpi_engine.sv]
// Table memories, binary search sequencer and interpolation for the profile block.
// Depends on rpi_pkg and rpi_div.
`default_nettype none
`include "assert_macros.svh"
module rpi_engine #(
  parameter int TABLE_DEPTH = rpi_pkg::TableDepthDef,
  parameter int VALUE_WIDTH = rpi_pkg::ValueWidthDef
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  input  wire logic [1:0]               mode,
  input  wire logic [rpi_pkg::RadW-1:0] radius,
  input  wire logic [4*rpi_pkg::QW-1:0] qin,
  input  wire logic [rpi_pkg::QW-1:0]   dflt_density,
  input  wire logic [rpi_pkg::QW-1:0]   dflt_temperature,
  input  wire logic [rpi_pkg::QW-1:0]   dflt_fraction,
  output logic                          busy,
  output logic                          done,
  output rpi_pkg::result_t              result
);
  import rpi_pkg::*;
  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int SW = (VALUE_WIDTH < QW) ? VALUE_WIDTH : QW;

  localparam logic [3:0] StIdle = 4'd0;
  localparam logic [3:0] StChkFirst = 4'd2;
  localparam logic [3:0] StChkLast = 4'd3;
  localparam logic [3:0] StSearch = 4'd4;
  localparam logic [3:0] StChkMid = 4'd5;
  localparam logic [3:0] StRdLo = 4'd6;
  localparam logic [3:0] StRdHi = 4'd7;
  localparam logic [3:0] StDiv = 4'd8;
  localparam logic [3:0] StMul = 4'd9;
  localparam logic [3:0] StSum = 4'd10;
  localparam logic [3:0] StDone = 4'd11;
  localparam logic [3:0] StRdRow = 4'd12;
  localparam logic [3:0] StRow = 4'd13;

  // Row memories with a registered, synchronous read.
  logic [RadW-1:0] rad_mem [TABLE_DEPTH];
  logic [4*SW-1:0] q_mem [TABLE_DEPTH];
  logic [RadW-1:0] rad_rd;
  logic [4*SW-1:0] q_rd;
  logic [AW-1:0] raddr;
  logic we;
  logic [AW-1:0] waddr;
  logic [4*SW-1:0] wq;

  always_ff @(posedge clk) begin
    if (we) begin
      rad_mem[waddr] <= radius;
      q_mem[waddr] <= wq;
    end
    rad_rd <= rad_mem[raddr];
    q_rd <= q_mem[raddr];
  end

  always_comb begin
    for (int k = 0; k < 4; k++) wq[k*SW +: SW] = qin[k*QW +: SW];
  end

  logic [3:0] st_r, st_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [AW-1:0] lo_r, lo_nxt, hi_r, hi_nxt, mid;
  logic [RadW-1:0] r_r, rlo_r, rlo_nxt, rhi_r, rhi_nxt;
  logic [4*SW-1:0] qlo_r, qlo_nxt;
  logic [WgtW-1:0] wgt_r;
  logic div_start, div_done;
  logic [WgtW-1:0] div_wgt;
  logic [1:0] lane_r, lane_nxt;
  logic [SW+WgtW+1:0] mul_full;
  logic [SW+WgtW:0] prod_r;
  logic [SW-1:0] low_r;
  result_t res_r, res_nxt;
  logic [RadW-1:0] off, span;
  logic [SW:0] dlane;
  logic [SW-1:0] lane_lo, lane_hi, fin;
  logic [SW+WgtW:0] sh;

  assign mid = lo_r + ((hi_r - lo_r) >> 1);
  assign span = rhi_r - rlo_r;
  assign off = (r_r > rlo_r) ? ((r_r - rlo_r > span) ? span : r_r - rlo_r) : '0;
  assign lane_lo = qlo_r[lane_r*SW +: SW];
  assign lane_hi = q_rd[lane_r*SW +: SW];
  assign dlane = {lane_hi[SW-1], lane_hi} - {lane_lo[SW-1], lane_lo};
  // Weight times the lane difference; the magnitude stays below 2^48.
  assign mul_full = $signed({1'b0, wgt_r}) * $signed(dlane);
  // Arithmetic shift gives the floor for either sign of the difference.
  assign sh = $signed(prod_r) >>> WgtW;
  assign fin = low_r + sh[SW-1:0];

  rpi_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .off(off), .span(span),
    .done(div_done), .wgt(div_wgt)
  );

  always_comb begin
    st_nxt = st_r;
    cnt_nxt = cnt_r;
    lo_nxt = lo_r;
    hi_nxt = hi_r;
    rlo_nxt = rlo_r;
    rhi_nxt = rhi_r;
    qlo_nxt = qlo_r;
    lane_nxt = lane_r;
    res_nxt = res_r;
    raddr = '0;
    we = 1'b0;
    waddr = cnt_r[AW-1:0];
    case (st_r)
      StIdle: begin
        if (start) begin
          res_nxt = '0;
          st_nxt = StDone;
          case (mode)
            ModeAppend: begin
              if (cnt_r == CW'(TABLE_DEPTH)) res_nxt.status = 1'b1;
              else begin
                we = 1'b1;
                cnt_nxt = cnt_r + 1'b1;
              end
            end
            ModeClear: cnt_nxt = '0;
            ModeQuery: begin
              if (cnt_r == '0) begin
                res_nxt.density = dflt_density;
                res_nxt.temperature = dflt_temperature;
                res_nxt.fraction = dflt_fraction;
              end else begin
                raddr = '0;
                st_nxt = StChkFirst;
              end
            end
            default: ;
          endcase
        end
      end
      StChkFirst: begin
        raddr = AW'(cnt_r - 1'b1);
        if (r_r <= rad_rd) begin
          lo_nxt = '0;
          st_nxt = StRdRow;
          raddr = '0;
        end else begin
          st_nxt = StChkLast;
        end
      end
      StChkLast: begin
        if (r_r >= rad_rd) begin
          lo_nxt = AW'(cnt_r - 1'b1);
          raddr = lo_nxt;
          st_nxt = StRdRow;
        end else begin
          lo_nxt = '0;
          hi_nxt = AW'(cnt_r - 1'b1);
          st_nxt = StSearch;
        end
      end
      StSearch: begin
        if (hi_r - lo_r > 1) begin
          raddr = mid;
          st_nxt = StChkMid;
        end else begin
          raddr = lo_r;
          st_nxt = StRdLo;
        end
      end
      StChkMid: begin
        if (rad_rd <= r_r) lo_nxt = mid;
        else hi_nxt = mid;
        st_nxt = StSearch;
      end
      StRdLo: begin
        rlo_nxt = rad_rd;
        qlo_nxt = q_rd;
        raddr = hi_r;
        st_nxt = StRdHi;
      end
      StRdHi: begin
        raddr = hi_r;
        rhi_nxt = rad_rd;
        st_nxt = StDiv;
      end
      StDiv: begin
        raddr = hi_r;
        if (div_done || !(rhi_r > rlo_r)) begin
          lane_nxt = 2'd0;
          st_nxt = StMul;
        end
      end
      StMul: begin
        raddr = hi_r;
        st_nxt = StSum;
      end
      StSum: begin
        raddr = hi_r;
        case (lane_r)
          2'd0: res_nxt.density = QW'($signed(fin));
          2'd1: res_nxt.temperature = QW'($signed(fin));
          2'd2: res_nxt.fraction = QW'($signed(fin));
          default: res_nxt.velocity = QW'($signed(fin));
        endcase
        lane_nxt = lane_r + 2'd1;
        st_nxt = (lane_r == 2'd3) ? StDone : StMul;
      end
      StRdRow: begin
        raddr = lo_r;
        st_nxt = StRow;
      end
      StRow: begin
        res_nxt.density = QW'($signed(q_rd[0 +: SW]));
        res_nxt.temperature = QW'($signed(q_rd[SW +: SW]));
        res_nxt.fraction = QW'($signed(q_rd[2*SW +: SW]));
        res_nxt.velocity = QW'($signed(q_rd[3*SW +: SW]));
        st_nxt = StDone;
      end
      StDone: st_nxt = StIdle;
      default: st_nxt = StIdle;
    endcase
  end

  // Divider launch is one pulse on entry to the weight step.
  logic div_go_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= StIdle;
      cnt_r <= '0;
      lane_r <= 2'd0;
      div_go_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      cnt_r <= cnt_nxt;
      lane_r <= lane_nxt;
      div_go_r <= (st_r == StRdHi);
    end
    lo_r <= lo_nxt;
    hi_r <= hi_nxt;
    rlo_r <= rlo_nxt;
    rhi_r <= rhi_nxt;
    qlo_r <= qlo_nxt;
    res_r <= res_nxt;
    if (start && st_r == StIdle) r_r <= radius;
    if (st_r == StRdHi) wgt_r <= '0;
    else if (div_done && st_r == StDiv) wgt_r <= div_wgt;
    // Multiply stage: one lane per pass, registered before the add.
    low_r <= lane_lo;
    prod_r <= mul_full[SW+WgtW:0];
  end

  // The divider only runs for a positive span; otherwise the weight stays 0.
  assign div_start = div_go_r && (rhi_r > rlo_r);

  assign busy = (st_r != StIdle);
  assign done = (st_r == StDone);
  assign result = res_r;

  `ASSERT_IMPL(a_cnt_max, clk, rst_n, 1'b1, cnt_r <= CW'(TABLE_DEPTH))
  `ASSERT_IMPL(a_order, clk, rst_n, st_r == StSearch, lo_r < hi_r)
  `ASSERT_NEXT(a_start_idle, clk, rst_n, start && st_r == StIdle, st_r != StIdle)
endmodule
`default_nettype wire

[design/radial_profile_interpolator.sv]
// Radial profile interpolator: row table in block memories, binary search query.
// Append, clear, unused mode and an empty query go straight to the done state; a clamped
// query returns the first or last row; an interpolated query is paced by the search reads,
// the 17-step divider (skipped for a non-increasing span) and one multiplier.
// One item at a time; a result waiting in the output register holds off the next item.
// Synchronous active-low reset empties the table and zeroes the default registers.
`default_nettype none
module radial_profile_interpolator #(
  parameter int TABLE_DEPTH = rpi_pkg::TableDepthDef,
  parameter int VALUE_WIDTH = rpi_pkg::ValueWidthDef
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // tdata: radius[31:0], density_in, temperature_in, fraction_in, velocity_in
  input  wire logic [159:0] s_axis_tdata,
  // tuser: mode[1:0]
  input  wire logic [1:0]   s_axis_tuser,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // tdata: density_out, temperature_out, fraction_out, velocity_out
  output logic [127:0]      m_axis_tdata,
  // tuser: status
  output logic              m_axis_tuser,
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [1:0]   cfg_index,
  input  wire logic [31:0]  cfg_data
);
  import rpi_pkg::*;
  logic [QW-1:0] dd_r, dt_r, df_r;
  logic busy, done, start;
  result_t res;
  logic ov_r;
  logic [127:0] od_r;
  logic os_r;

  assign s_axis_tready = rst_n && !busy && !(ov_r && !m_axis_tready);
  assign start = s_axis_tvalid && s_axis_tready;
  assign cfg_ready = rst_n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dd_r <= '0;
      dt_r <= '0;
      df_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CfgDensity: dd_r <= cfg_data;
        CfgTemperature: dt_r <= cfg_data;
        CfgFraction: df_r <= cfg_data;
        default: ;
      endcase
    end
  end

  rpi_engine #(.TABLE_DEPTH(TABLE_DEPTH), .VALUE_WIDTH(VALUE_WIDTH)) u_eng (
    .clk(clk), .rst_n(rst_n), .start(start), .mode(s_axis_tuser),
    .radius(s_axis_tdata[31:0]), .qin(s_axis_tdata[159:32]),
    .dflt_density(dd_r), .dflt_temperature(dt_r), .dflt_fraction(df_r),
    .busy(busy), .done(done), .result(res)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) ov_r <= 1'b0;
    else if (done) ov_r <= 1'b1;
    else if (m_axis_tready) ov_r <= 1'b0;
    if (done) begin
      od_r <= {res.velocity, res.fraction, res.temperature, res.density};
      os_r <= res.status;
    end
  end

  assign m_axis_tvalid = ov_r;
  assign m_axis_tdata = od_r;
  assign m_axis_tuser = os_r;
endmodule
`default_nettype wire
